// File: rtl/cdtf_pkg.sv
// Shared types and constants for the clipped depth-tested framebuffer.
`default_nettype none
package cdtf_pkg;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_TEST    = 3'd1;
  localparam logic [2:0] CMD_RDPIX   = 3'd2;
  localparam logic [2:0] CMD_RDDEPTH = 3'd3;
  localparam logic [2:0] CMD_FILL    = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [2:0] REG_SURF_W = 3'd0;
  localparam logic [2:0] REG_SURF_H = 3'd1;
  localparam logic [2:0] REG_CLIP_L = 3'd2;
  localparam logic [2:0] REG_CLIP_T = 3'd3;
  localparam logic [2:0] REG_CLIP_W = 3'd4;
  localparam logic [2:0] REG_CLIP_H = 3'd5;

  localparam int SURF_W = 9;
  localparam int COORD_W = 10;

  // classified command, as it travels from the front to the back
  typedef struct packed {
    logic [2:0]         cmd;
    logic               ok;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_last;
    logic [SURF_W-1:0]  stride;
    logic [31:0]        color;
    logic [15:0]        depth;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/cdtf_if.sv
// Channel interfaces: command input, result output and register writes.
`default_nettype none
interface cdtf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic [15:0]        depth_value;
  modport source(output valid, cmd, pos_x, pos_y, rect_width, rect_height, red, green, blue,
                 alpha, depth_value, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, rect_width, rect_height, red, green, blue,
               alpha, depth_value, output ready);
endinterface

interface cdtf_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  read_red;
  logic [7:0]  read_green;
  logic [7:0]  read_blue;
  logic [7:0]  read_alpha;
  logic [15:0] read_depth;
  modport source(output valid, accepted, read_red, read_green, read_blue, read_alpha,
                 read_depth, input ready);
  modport sink(input valid, accepted, read_red, read_green, read_blue, read_alpha,
               read_depth, output ready);
endinterface

interface cdtf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/clipped_depth_tested_framebuffer.sv
// Top level: framebuffer with RGBA and depth stores, clip rectangle and depth test.
//
//  channel   dir  word
//  cfg       in   register index, 16-bit write data (always ready)
//  pix_in    in   cmd, position, rect size, RGBA color, inverse depth
//  pix_out   out  accepted flag, RGBA read, depth read
//
// After reset both stores are zeroed, one entry per cycle; pix_in is not ready until
// all MAX_WIDTH*MAX_HEIGHT entries are cleared, while cfg writes are taken.
// Per word, the store sequencer stores a write from idle, reads the stores for a tested
// write or a read, walks the clipped area for a fill and every depth entry for a clear;
// failed bounds/clip checks, empty fills and unused codes go straight to the result.
// A two-entry queue lets pix_in keep accepting while a result waits on pix_out.
`default_nettype none
module clipped_depth_tested_framebuffer import cdtf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  cdtf_cfg_if.sink   cfg,
  cdtf_in_if.sink    pix_in,
  cdtf_out_if.source pix_out
);

  logic  push, pop, q_full, q_valid, init_busy;
  item_t push_item, head;

  cdtf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .cfg, .pix_in, .q_full, .init_busy, .push, .item(push_item)
  );

  cdtf_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .full(q_full), .q_valid, .head
  );

  cdtf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .q_valid, .head, .pop, .init_busy, .pix_out
  );

endmodule
`default_nettype wire

// File: rtl/cdtf_front.sv
// Front end: configuration registers, bounds/clip checks and fill rectangle clipping.
`default_nettype none
module cdtf_front import cdtf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  cdtf_cfg_if.sink   cfg,
  cdtf_in_if.sink    pix_in,
  input  logic       q_full,
  input  logic       init_busy,
  output logic       push,
  output item_t      item
);

  logic [SURF_W-1:0] surf_w;
  logic [SURF_W-1:0] surf_h;
  logic signed [15:0] clip_left;
  logic signed [15:0] clip_top;
  logic signed [15:0] clip_width;
  logic signed [15:0] clip_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surf_w      <= 9'd256;
      surf_h      <= 9'd256;
      clip_left   <= 16'sd0;
      clip_top    <= 16'sd0;
      clip_width  <= 16'sd256;
      clip_height <= 16'sd256;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SURF_W: surf_w      <= cfg.data[SURF_W-1:0];
        REG_SURF_H: surf_h      <= cfg.data[SURF_W-1:0];
        REG_CLIP_L: clip_left   <= cfg.data;
        REG_CLIP_T: clip_top    <= cfg.data;
        REG_CLIP_W: clip_width  <= cfg.data;
        REG_CLIP_H: clip_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign pix_in.ready = !q_full && !init_busy;
  assign push = pix_in.valid && pix_in.ready;

  logic [SURF_W-1:0] eff_w, eff_h;
  assign eff_w = ({23'd0, surf_w} > 32'(MAX_WIDTH))  ? SURF_W'(MAX_WIDTH)  : surf_w;
  assign eff_h = ({23'd0, surf_h} > 32'(MAX_HEIGHT)) ? SURF_W'(MAX_HEIGHT) : surf_h;

  logic signed [17:0] xs, ys, ew, eh, cl, ct, cr, cb, xe, ye;
  logic signed [17:0] mx, my, x0, y0, nx, ny, x1, y1, xl, yl;
  logic inb, inc, fill_ok;

  always_comb begin
    xs = 18'(pix_in.pos_x);
    ys = 18'(pix_in.pos_y);
    ew = $signed({9'd0, eff_w});
    eh = $signed({9'd0, eff_h});
    cl = 18'(clip_left);
    ct = 18'(clip_top);
    cr = cl + 18'(clip_width);
    cb = ct + 18'(clip_height);
    xe = xs + 18'(pix_in.rect_width);
    ye = ys + 18'(pix_in.rect_height);

    inb = (xs >= 18'sd0) && (ys >= 18'sd0) && (xs < ew) && (ys < eh);
    inc = (xs >= cl) && (ys >= ct) && (xs < cr) && (ys < cb);

    mx = (xs > 18'sd0) ? xs : 18'sd0;
    my = (ys > 18'sd0) ? ys : 18'sd0;
    x0 = (mx > cl) ? mx : cl;
    y0 = (my > ct) ? my : ct;
    nx = (ew < xe) ? ew : xe;
    ny = (eh < ye) ? eh : ye;
    x1 = (nx < cr) ? nx : cr;
    y1 = (ny < cb) ? ny : cb;
    xl = x1 - 18'sd1;
    yl = y1 - 18'sd1;
    fill_ok = (x1 > x0) && (y1 > y0);

    item.cmd    = pix_in.cmd;
    item.stride = eff_w;
    item.color  = {pix_in.red, pix_in.green, pix_in.blue, pix_in.alpha};
    item.depth  = pix_in.depth_value;
    item.x      = xs[COORD_W-1:0];
    item.y      = ys[COORD_W-1:0];
    item.x_last = xl[COORD_W-1:0];
    item.y_last = yl[COORD_W-1:0];
    case (pix_in.cmd)
      CMD_WRITE, CMD_TEST:    item.ok = inb && inc;
      CMD_RDPIX, CMD_RDDEPTH: item.ok = inb;
      CMD_FILL: begin
        item.ok = fill_ok;
        item.x  = x0[COORD_W-1:0];
        item.y  = y0[COORD_W-1:0];
      end
      default: item.ok = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cdtf_queue.sv
// Two-entry queue between the front end and the store sequencer.
`default_nettype none
module cdtf_queue import cdtf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  q_valid,
  output item_t head
);

  item_t slots [2];
  logic wp, rp;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head    = slots[rp];
  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);

endmodule
`default_nettype wire

// File: rtl/cdtf_back.sv
// Back end: pixel and depth memories, command sequencer and result register.
`default_nettype none
module cdtf_back import cdtf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      head,
  output logic       pop,
  output logic       init_busy,
  cdtf_out_if.source pix_out
);

  localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam logic [AW-1:0] Last = AW'(StoreSize - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_TEST, ST_READ, ST_FILL, ST_CLEAR, ST_EMIT
  } state_t;

  state_t state;
  item_t cur;
  logic [AW-1:0] cnt, addr, row, head_addr;
  logic [COORD_W-1:0] px, py;
  logic [19:0] lin;

  logic res_acc;
  logic [31:0] res_pix;
  logic [15:0] res_dep;
  logic out_valid;
  logic out_acc;
  logic [31:0] out_pix;
  logic [15:0] out_dep;

  logic [31:0] pix_mem [StoreSize];
  logic [15:0] dep_mem [StoreSize];
  logic [31:0] pix_rd;
  logic [15:0] dep_rd;

  logic pm_we, dm_we;
  logic [AW-1:0] pm_wa, dm_wa;
  logic [31:0] pm_wd;
  logic [15:0] dm_wd;
  logic out_free, depth_pass;

  assign lin = 20'(head.y) * 20'(head.stride) + 20'(head.x);
  assign head_addr = AW'(lin);
  assign out_free = !out_valid || pix_out.ready;
  assign depth_pass = (cur.depth >= dep_rd);
  assign pop = (state == ST_IDLE) && q_valid;
  assign init_busy = (state == ST_INIT);

  // reads always follow the queue head; the data is used the cycle after a pop
  always_ff @(posedge clk) begin
    if (pm_we) pix_mem[pm_wa] <= pm_wd;
    pix_rd <= pix_mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dep_mem[dm_wa] <= dm_wd;
    dep_rd <= dep_mem[head_addr];
  end

  always_comb begin
    pm_we = 1'b0;
    pm_wa = addr;
    pm_wd = cur.color;
    dm_we = 1'b0;
    dm_wa = addr;
    dm_wd = cur.depth;
    case (state)
      ST_INIT: begin
        pm_we = 1'b1;
        pm_wa = cnt;
        pm_wd = 32'd0;
        dm_we = 1'b1;
        dm_wa = cnt;
        dm_wd = 16'd0;
      end
      ST_IDLE: begin
        pm_we = q_valid && (head.cmd == CMD_WRITE) && head.ok;
        pm_wa = head_addr;
        pm_wd = head.color;
      end
      ST_TEST: begin
        pm_we = depth_pass;
        dm_we = depth_pass;
      end
      ST_FILL:  pm_we = 1'b1;
      ST_CLEAR: begin
        dm_we = 1'b1;
        dm_wa = cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // ST_EMIT loads the result register itself
      if (out_valid && pix_out.ready && (state != ST_EMIT)) out_valid <= 1'b0;
      case (state)
        ST_INIT: begin
          cnt <= cnt + AW'(1);
          if (cnt == Last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur     <= head;
            addr    <= head_addr;
            row     <= head_addr;
            px      <= head.x;
            py      <= head.y;
            cnt     <= '0;
            res_acc <= (head.cmd == CMD_WRITE) && head.ok;
            res_pix <= 32'd0;
            res_dep <= 16'd0;
            case (head.cmd)
              CMD_WRITE:              state <= ST_EMIT;
              CMD_TEST:               state <= head.ok ? ST_TEST : ST_EMIT;
              CMD_RDPIX, CMD_RDDEPTH: state <= head.ok ? ST_READ : ST_EMIT;
              CMD_FILL:               state <= head.ok ? ST_FILL : ST_EMIT;
              CMD_CLEAR:              state <= ST_CLEAR;
              default:                state <= ST_EMIT;
            endcase
          end
        end
        ST_TEST: begin
          res_acc <= depth_pass;
          state   <= ST_EMIT;
        end
        ST_READ: begin
          if (cur.cmd == CMD_RDPIX) res_pix <= pix_rd;
          else res_dep <= dep_rd;
          state <= ST_EMIT;
        end
        ST_FILL: begin
          if (px == cur.x_last) begin
            if (py == cur.y_last) begin
              res_acc <= 1'b1;
              state   <= ST_EMIT;
            end else begin
              py   <= py + COORD_W'(1);
              px   <= cur.x;
              row  <= row + AW'(cur.stride);
              addr <= row + AW'(cur.stride);
            end
          end else begin
            px   <= px + COORD_W'(1);
            addr <= addr + AW'(1);
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt == Last) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_acc   <= res_acc;
            out_pix   <= res_pix;
            out_dep   <= res_dep;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.accepted   = out_acc;
  assign pix_out.read_red   = out_pix[31:24];
  assign pix_out.read_green = out_pix[23:16];
  assign pix_out.read_blue  = out_pix[15:8];
  assign pix_out.read_alpha = out_pix[7:0];
  assign pix_out.read_depth = out_dep;

endmodule
`default_nettype wire

// File: rtl/cdtf_checker.sv
// Port-level checks on the framebuffer result channel, bound to the top level.
`default_nettype none
module cdtf_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [7:0]  read_red,
  input logic [7:0]  read_green,
  input logic [7:0]  read_blue,
  input logic [7:0]  read_alpha,
  input logic [15:0] read_depth
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stored write never carries read data
  a_acc_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> read_red == 8'd0 && read_green == 8'd0 &&
      read_blue == 8'd0 && read_alpha == 8'd0 && read_depth == 16'd0)
    else $error("accepted word has read data");

  a_depth_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_depth != 16'd0 |-> read_red == 8'd0 && read_green == 8'd0 &&
      read_blue == 8'd0 && read_alpha == 8'd0)
    else $error("depth read mixed with pixel data");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind clipped_depth_tested_framebuffer cdtf_port_checks u_chk (
  .clk(clk),
  .rst(rst),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .accepted(pix_out.accepted),
  .read_red(pix_out.read_red),
  .read_green(pix_out.read_green),
  .read_blue(pix_out.read_blue),
  .read_alpha(pix_out.read_alpha),
  .read_depth(pix_out.read_depth)
);
`default_nettype wire

// File: bench/cdtf_checker.sv
// Checker: watches the framebuffer channels, predicts each result and compares it.
module cdtf_checker import cdtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cdtf_cfg_if        cfg,
  cdtf_in_if         pix_in,
  cdtf_out_if        pix_out,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  localparam int FB_SIZE = FB_W * FB_H;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] depth;
  } result_t;

  logic [31:0] color_mem [FB_SIZE];
  logic [15:0] zbuf_mem [FB_SIZE];
  logic [8:0]  surf_w, surf_h;
  longint      clip_l, clip_t, clip_w, clip_h;
  result_t     expected_results[$];

  function automatic longint eff_w();
    return (surf_w > FB_W) ? FB_W : surf_w;
  endfunction

  function automatic longint eff_h();
    return (surf_h > FB_H) ? FB_H : surf_h;
  endfunction

  function automatic bit on_surface(longint x, longint y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic bit in_scissor(longint x, longint y);
    return x >= clip_l && y >= clip_t && x < clip_l + clip_w && y < clip_t + clip_h;
  endfunction

  function automatic int addr_of(longint x, longint y);
    return int'((y * eff_w() + x) % FB_SIZE);
  endfunction

  function automatic result_t render_cmd(logic [2:0] cmd, longint x, longint y, longint rw,
                                         longint rh, logic [31:0] color, logic [15:0] z);
    result_t r;
    int      k;
    longint  x0, y0, x1, y1;
    r = '0;
    case (cmd)
      CMD_WRITE: begin
        if (on_surface(x, y) && in_scissor(x, y)) begin
          color_mem[addr_of(x, y)] = color;
          r.accepted = 1'b1;
        end
      end
      CMD_TEST: begin
        if (on_surface(x, y) && in_scissor(x, y)) begin
          k = addr_of(x, y);
          if (z >= zbuf_mem[k]) begin
            zbuf_mem[k] = z;
            color_mem[k] = color;
            r.accepted = 1'b1;
          end
        end
      end
      CMD_RDPIX: begin
        if (on_surface(x, y))
          {r.red, r.green, r.blue, r.alpha} = color_mem[addr_of(x, y)];
      end
      CMD_RDDEPTH: begin
        if (on_surface(x, y))
          r.depth = zbuf_mem[addr_of(x, y)];
      end
      CMD_FILL: begin
        x0 = (x > 0) ? x : 0;
        if (clip_l > x0) x0 = clip_l;
        y0 = (y > 0) ? y : 0;
        if (clip_t > y0) y0 = clip_t;
        x1 = (x + rw < eff_w()) ? x + rw : eff_w();
        if (clip_l + clip_w < x1) x1 = clip_l + clip_w;
        y1 = (y + rh < eff_h()) ? y + rh : eff_h();
        if (clip_t + clip_h < y1) y1 = clip_t + clip_h;
        if (x1 > x0 && y1 > y0) begin
          for (longint py = y0; py < y1; py++)
            for (longint px = x0; px < x1; px++)
              color_mem[addr_of(px, py)] = color;
          r.accepted = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < FB_SIZE; i++) zbuf_mem[i] = z;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want, pred;
    if (rst) begin
      for (int i = 0; i < FB_SIZE; i++) begin
        color_mem[i] = '0;
        zbuf_mem[i] = '0;
      end
      surf_w = 9'd256;
      surf_h = 9'd256;
      clip_l = 0;
      clip_t = 0;
      clip_w = 256;
      clip_h = 256;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SURF_W: surf_w = cfg.data[8:0];
          REG_SURF_H: surf_h = cfg.data[8:0];
          REG_CLIP_L: clip_l = longint'($signed(cfg.data));
          REG_CLIP_T: clip_t = longint'($signed(cfg.data));
          REG_CLIP_W: clip_w = longint'($signed(cfg.data));
          REG_CLIP_H: clip_h = longint'($signed(cfg.data));
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        pred = render_cmd(pix_in.cmd, pix_in.pos_x, pix_in.pos_y,
          pix_in.rect_width, pix_in.rect_height,
          {pix_in.red, pix_in.green, pix_in.blue, pix_in.alpha}, pix_in.depth_value);
        expected_results.insert(expected_results.size(), pred);
      end
      if (pix_out.valid && pix_out.ready) begin
        got = {pix_out.accepted, pix_out.read_red, pix_out.read_green, pix_out.read_blue,
               pix_out.read_alpha, pix_out.read_depth};
        if (expected_results.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
            errors++;
          end
          if (got.red !== want.red) begin
            $error("read_red: expected %0d actual %0d", want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $error("read_green: expected %0d actual %0d", want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $error("read_blue: expected %0d actual %0d", want.blue, got.blue);
            errors++;
          end
          if (got.alpha !== want.alpha) begin
            $error("read_alpha: expected %0d actual %0d", want.alpha, got.alpha);
            errors++;
          end
          if (got.depth !== want.depth) begin
            $error("read_depth: expected %0d actual %0d", want.depth, got.depth);
            errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

// File: bench/tb_clipped_depth_tested_framebuffer.sv
// Testbench top: clock, reset, command and register stimulus, verdict.
module tb_clipped_depth_tested_framebuffer;
  import cdtf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  bit   quiet = 1'b0;
  bit   hold_off = 1'b0;
  int   words_sent = 0;

  cdtf_cfg_if cfg();
  cdtf_in_if  pix_in();
  cdtf_out_if pix_out();

  clipped_depth_tested_framebuffer u_top (
    .clk(clk), .rst(rst), .cfg(cfg), .pix_in(pix_in), .pix_out(pix_out)
  );

  cdtf_checker u_checker (
    .clk(clk), .rst(rst), .cfg(cfg), .pix_in(pix_in), .pix_out(pix_out),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off
  initial begin
    pix_out.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        pix_out.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        pix_out.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_surface(logic [15:0] w, logic [15:0] h, logic [15:0] cl,
                             logic [15:0] ct, logic [15:0] cw, logic [15:0] ch);
    write_reg(REG_SURF_W, w);
    write_reg(REG_SURF_H, h);
    write_reg(REG_CLIP_L, cl);
    write_reg(REG_CLIP_T, ct);
    write_reg(REG_CLIP_W, cw);
    write_reg(REG_CLIP_H, ch);
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [15:0] x, logic [15:0] y, logic [15:0] rw,
                          logic [15:0] rh, logic [31:0] color, logic [15:0] z);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.cmd <= cmd;
    pix_in.pos_x <= x;
    pix_in.pos_y <= y;
    pix_in.rect_width <= rw;
    pix_in.rect_height <= rh;
    {pix_in.red, pix_in.green, pix_in.blue, pix_in.alpha} <= color;
    pix_in.depth_value <= z;
    do @(posedge clk); while (!pix_in.ready);
    words_sent++;
  endtask

  // let the clock tick first so the last accepted word is already counted as pending
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  // coordinate near the surface, now and then any 16-bit value
  function automatic logic [15:0] rand_coord(int span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, span + 8) - 4);
  endfunction

  task automatic random_cmds(int count, int span);
    logic [2:0]  cmd;
    logic [15:0] rw, rh;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:      cmd = CMD_WRITE;
        5, 6, 7, 8, 9:      cmd = CMD_TEST;
        10, 11, 12, 13:     cmd = CMD_RDPIX;
        14, 15, 16:         cmd = CMD_RDDEPTH;
        17, 18:             cmd = CMD_FILL;
        default:            cmd = 3'($urandom_range(6, 7));
      endcase
      // keep fill area small: one side stays short
      rw = 16'($urandom_range(0, 10) - 2);
      rh = 16'($urandom_range(0, 5) - 2);
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) rw = 16'($urandom);
        else rh = 16'($urandom);
      end
      send_cmd(cmd, rand_coord(span), rand_coord(span), rw, rh, $urandom,
               16'($urandom));
    end
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    pix_in.valid = 1'b0;
    pix_in.cmd = '0;
    pix_in.pos_x = '0;
    pix_in.pos_y = '0;
    pix_in.rect_width = '0;
    pix_in.rect_height = '0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    pix_in.alpha = '0;
    pix_in.depth_value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners, bounds, depth compare, fills, clears, unused codes
    send_cmd(CMD_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
    send_cmd(CMD_WRITE, 16'd255, 16'd255, 16'd0, 16'd0, 32'h1234_5678, 16'd0);
    send_cmd(CMD_WRITE, 16'hFFFF, 16'd0, 16'd0, 16'd0, 32'hAAAA_AAAA, 16'd0);
    send_cmd(CMD_WRITE, 16'd256, 16'd0, 16'd0, 16'd0, 32'h5555_5555, 16'd0);
    send_cmd(CMD_RDPIX, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_RDPIX, 16'd255, 16'd255, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_RDPIX, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_TEST, 16'd5, 16'd5, 16'd0, 16'd0, 32'h0102_0304, 16'd0);
    send_cmd(CMD_TEST, 16'd5, 16'd5, 16'd0, 16'd0, 32'h0506_0708, 16'd100);
    send_cmd(CMD_TEST, 16'd5, 16'd5, 16'd0, 16'd0, 32'h090A_0B0C, 16'd50);
    send_cmd(CMD_TEST, 16'd6, 16'd5, 16'd0, 16'd0, 32'h0D0E_0F10, 16'hFFFF);
    send_cmd(CMD_RDDEPTH, 16'd5, 16'd5, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_RDDEPTH, 16'd6, 16'd5, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_RDDEPTH, 16'd5, 16'h8000, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_FILL, 16'hFFF6, 16'hFFF6, 16'd20, 16'd20, 32'hCAFE_F00D, 16'd0);
    send_cmd(CMD_FILL, 16'd3, 16'd3, 16'd0, 16'd4, 32'hDEAD_0000, 16'd0);
    send_cmd(CMD_FILL, 16'd3, 16'd3, 16'h8000, 16'd4, 32'hDEAD_0001, 16'd0);
    send_cmd(CMD_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h0F0F_0F0F, 16'd0);
    send_cmd(CMD_RDPIX, 16'd9, 16'd9, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(CMD_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 16'hABCD);
    send_cmd(CMD_RDDEPTH, 16'd200, 16'd100, 16'd0, 16'd0, 32'd0, 16'd0);
    send_cmd(3'd6, 16'd1, 16'd1, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(3'd7, 16'd1, 16'd1, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(CMD_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    drain();

    // phase: default surface, written explicitly; long result hold-off midway
    set_surface(16'd256, 16'd256, 16'd0, 16'd0, 16'd256, 16'd256);
    random_cmds(100, 256);
    hold_off = 1'b1;
    random_cmds(250, 256);
    drain();

    set_surface(16'd16, 16'd12, 16'd2, 16'd3, 16'd10, 16'd7);
    random_cmds(350, 16);
    drain();

    // oversized surface, clip reaching past it on all sides
    set_surface(16'd511, 16'd300, 16'hFFFB, 16'hFFFB, 16'h7FFF, 16'h7FFF);
    random_cmds(300, 256);
    drain();

    set_surface(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256);
    random_cmds(150, 8);
    drain();

    // nothing passes the clip: negative width, then edge at the top of the range
    set_surface(16'd8, 16'd8, 16'h8000, 16'd0, 16'h8000, 16'd5);
    random_cmds(150, 8);
    drain();
    set_surface(16'd1, 16'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    random_cmds(150, 4);
    drain();

    quiet = 1'b1;
    set_surface(16'd64, 16'd33, 16'd8, 16'd4, 16'd30, 16'd20);
    random_cmds(550, 64);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
